// ----- hdl/gcd_pkg.sv -----
// Package for the GCD/LCM unit: operand width, transaction structs,
// microcode control word types and the microprogram ROM.
// No dependencies.
`default_nettype none

package gcd_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH + 1);
    localparam int STEP_W        = 4;

    typedef struct packed {
        logic [31:0] operand_x;
        logic [31:0] operand_y;
    } t_in_item;

    typedef struct packed {
        logic [31:0] gcd_value;
        logic [63:0] lcm_value;
        logic        both_zero;
    } t_out_item;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DIV_MOD,   // start divider on p / q
        OP_DIV_LCM,   // start divider on x / p
        OP_SWAP,      // p <= q, q <= remainder
        OP_CLR_LCM,
        OP_MUL,       // lcm <= quotient * y
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_Q_ZERO,
        C_P_ZERO,
        C_DIV_BUSY,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_cword;

    localparam t_step ST_LOOP     = 4'd0;
    localparam t_step ST_MOD_GO   = 4'd1;
    localparam t_step ST_MOD_WAIT = 4'd2;
    localparam t_step ST_SWAP     = 4'd3;
    localparam t_step ST_CHK_G    = 4'd4;
    localparam t_step ST_DIV_GO   = 4'd5;
    localparam t_step ST_DIV_WAIT = 4'd6;
    localparam t_step ST_MUL      = 4'd7;
    localparam t_step ST_OUT      = 4'd8;

    function automatic t_cword ucode(input t_step step);
        t_cword cw;
        case (step)
            ST_LOOP:     cw = '{op: OP_NOP,     cond: C_Q_ZERO,   target: ST_CHK_G};
            ST_MOD_GO:   cw = '{op: OP_DIV_MOD, cond: C_NEVER,    target: ST_LOOP};
            ST_MOD_WAIT: cw = '{op: OP_NOP,     cond: C_DIV_BUSY, target: ST_MOD_WAIT};
            ST_SWAP:     cw = '{op: OP_SWAP,    cond: C_ALWAYS,   target: ST_LOOP};
            ST_CHK_G:    cw = '{op: OP_CLR_LCM, cond: C_P_ZERO,   target: ST_OUT};
            ST_DIV_GO:   cw = '{op: OP_DIV_LCM, cond: C_NEVER,    target: ST_LOOP};
            ST_DIV_WAIT: cw = '{op: OP_NOP,     cond: C_DIV_BUSY, target: ST_DIV_WAIT};
            ST_MUL:      cw = '{op: OP_MUL,     cond: C_NEVER,    target: ST_LOOP};
            ST_OUT:      cw = '{op: OP_OUT,     cond: C_OUT_BUSY, target: ST_OUT};
            default:     cw = '{op: OP_NOP,     cond: C_ALWAYS,   target: ST_OUT};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gcd_lcm_unit_top.sv -----
// GCD/LCM unit top level: microcoded sequencer, shared restoring divider
// and one registered multiplier.
// Depends on gcd_pkg.
//
// Usage:
//   Input channel i_valid / o_stall carries operand_x and operand_y; a
//   transaction completes when i_valid is high and o_stall is low.
//   Output channel o_valid / i_stall carries gcd_value, lcm_value and
//   both_zero; one result per input transaction.
//   Only the low OPERAND_WIDTH bits of each operand are used.
//   One operand pair is worked at a time; o_stall is high while it runs.
//   Each Euclid remainder step runs the shared divider (it retires one
//   quotient bit per cycle), then the final x / gcd runs on it as well,
//   with microcode sequencing steps around the divider runs.
//   The result sits in an output register; a new pair may be accepted
//   while it waits; the sequencer only holds at its last step if the output
//   register is still full and stalled when the next result is ready.
//   Synchronous active-low reset empties the sequencer and output register.
`default_nettype none

module gcd_lcm_unit_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire gcd_pkg::t_in_item i_in,
    output logic                 o_valid,
    input  wire                  i_stall,
    output gcd_pkg::t_out_item   o_out
);
    import gcd_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic                r_busy;
    t_step               r_step;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [W-1:0]        r_x, r_y, r_p, r_q;
    logic                r_both_zero;
    logic [2*W-1:0]      r_lcm;

    logic [W-1:0]        r_div_rem, r_div_quo, r_div_dvs;
    logic [CNT_W-1:0]    r_div_cnt;

    t_cword              cw;
    logic                take;
    logic                out_busy;
    logic                div_busy;
    logic                jump;
    logic                in_acc;
    logic [W:0]          div_shift;
    logic [W:0]          div_trial;
    t_step               n_step;

    assign in_acc    = i_valid && !r_busy;
    assign o_stall   = r_busy;
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;

    assign cw        = ucode(r_step);
    assign out_busy  = r_out_valid && i_stall;
    assign div_busy  = (r_div_cnt != '0);
    assign div_shift = {r_div_rem, r_div_quo[W-1]};
    assign div_trial = div_shift - {1'b0, r_div_dvs};

    always_comb begin
        case (cw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_Q_ZERO:   jump = (r_q == '0);
            C_P_ZERO:   jump = (r_p == '0);
            C_DIV_BUSY: jump = div_busy;
            C_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b0;
        endcase
        n_step = jump ? cw.target : r_step + t_step'(1);
        take   = r_busy && (cw.op == OP_OUT) && !out_busy;
    end

    // sequencer, divider counter and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_LOOP;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_step <= ST_LOOP;
            end else if (r_busy) begin
                r_step <= n_step;
                if (take) begin
                    r_busy <= 1'b0;
                end
            end

            if (take) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_busy && (cw.op == OP_DIV_MOD || cw.op == OP_DIV_LCM)) begin
                r_div_cnt <= CNT_W'(W);
            end else if (div_busy) begin
                r_div_cnt <= r_div_cnt - CNT_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x         <= i_in.operand_x[W-1:0];
            r_y         <= i_in.operand_y[W-1:0];
            r_p         <= i_in.operand_x[W-1:0];
            r_q         <= i_in.operand_y[W-1:0];
            r_both_zero <= (i_in.operand_x[W-1:0] == '0) && (i_in.operand_y[W-1:0] == '0);
        end else if (r_busy) begin
            case (cw.op)
                OP_DIV_MOD: begin
                    r_div_rem <= '0;
                    r_div_quo <= r_p;
                    r_div_dvs <= r_q;
                end
                OP_DIV_LCM: begin
                    r_div_rem <= '0;
                    r_div_quo <= r_x;
                    r_div_dvs <= r_p;
                end
                OP_SWAP: begin
                    r_p <= r_q;
                    r_q <= r_div_rem;
                end
                OP_CLR_LCM: r_lcm <= '0;
                OP_MUL:     r_lcm <= (2*W)'(r_div_quo) * (2*W)'(r_y);
                default: ;
            endcase
        end

        if (div_busy) begin
            if (!div_trial[W]) begin
                r_div_rem <= div_trial[W-1:0];
                r_div_quo <= {r_div_quo[W-2:0], 1'b1};
            end else begin
                r_div_rem <= div_shift[W-1:0];
                r_div_quo <= {r_div_quo[W-2:0], 1'b0};
            end
        end

        if (take) begin
            r_out.gcd_value <= 32'(r_p);
            r_out.lcm_value <= 64'(r_lcm);
            r_out.both_zero <= r_both_zero;
        end
    end

    a_div_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> r_busy)
        else $error("divider running while sequencer idle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_busy && r_step == ST_LOOP))
        else $error("accepted transaction did not start the program");

    a_no_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && cw.op == OP_DIV_MOD) |-> (r_q != '0))
        else $error("remainder step started with zero divisor");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_out.both_zero |->
            (r_out.gcd_value == '0 && r_out.lcm_value == '0))
        else $error("both-zero result carries nonzero values");

endmodule

`default_nettype wire

// ----- test/tb_gcd_lcm_unit_top.sv -----
// Testbench for gcd_lcm_unit_top. It sends directed and random operand pairs,
// predicts the GCD/LCM of each pair and checks every result transaction.
// Depends on gcd_pkg and gcd_lcm_unit_top.

module tb_gcd_lcm_unit_top;

    import gcd_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_ITEMS  = 120;
    localparam int END_WAIT    = 200;
    localparam int RAND_ITEMS  = 1400;

    typedef struct packed {
        logic     hold;
        t_in_item pair;
    } t_pending;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_in    = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_out;

    t_pending    pending_q[$];
    t_out_item   expected_q[$];
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned idle_pct     = 20;
    int unsigned stall_pct    = 20;
    logic        tail_phase   = 1'b0;

    gcd_lcm_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out_item gcd_lcm_of(input t_in_item pair);
        t_out_item   res;
        logic [63:0] mask;
        logic [31:0] x, y, p, q, rem;
        mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
        x = pair.operand_x & mask[31:0];
        y = pair.operand_y & mask[31:0];
        res = '0;
        if (x == 0 && y == 0) begin
            res.both_zero = 1'b1;
        end else if (x == 0) begin
            res.gcd_value = y;
        end else if (y == 0) begin
            res.gcd_value = x;
        end else begin
            p = x;
            q = y;
            while (q != 0) begin
                rem = p % q;
                p = q;
                q = rem;
            end
            res.gcd_value = p;
            res.lcm_value = {32'd0, x / p} * {32'd0, y};
        end
        return res;
    endfunction

    task automatic add_pair(input logic [31:0] x, input logic [31:0] y, input logic hold);
        t_pending ent;
        ent.hold = hold;
        ent.pair.operand_x = x;
        ent.pair.operand_y = y;
        pending_q.push_back(ent);
    endtask

    // driver
    always @(posedge i_clk) begin
        int unsigned sent_now;
        logic        go;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            items_sent <= 0;
            tail_phase <= 1'b0;
            gap_left = 0;
        end else begin
            sent_now = items_sent;
            if (i_valid && !o_stall) begin
                void'(pending_q.pop_front());
                sent_now++;
                items_sent <= sent_now;
                if (sent_now % 40 == 0) begin
                    case ($urandom_range(2))
                        0: idle_pct = 0;
                        1: idle_pct = 20;
                        default: idle_pct = 50;
                    endcase
                end
            end
            if (!(i_valid && o_stall)) begin
                go = 1'b0;
                if (pending_q.size() != 0) begin
                    if (pending_q[0].hold) begin
                        if (sent_now == results_seen)
                            pending_q[0].hold = 1'b0;
                    end else if (gap_left != 0) begin
                        gap_left--;
                    end else if (pending_q.size() > TAIL_ITEMS &&
                                 $urandom_range(99) < idle_pct) begin
                        gap_left = $urandom_range(7, 1) - 1;
                    end else begin
                        go = 1'b1;
                    end
                end
                if (go)
                    i_in <= pending_q[0].pair;
                i_valid <= go;
            end
            tail_phase <= (pending_q.size() <= TAIL_ITEMS);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            results_seen <= 0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, got %h",
                             $time, o_out);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_out.gcd_value !== want.gcd_value) begin
                        $display("%0t: gcd_value mismatch, expected %h, got %h",
                                 $time, want.gcd_value, o_out.gcd_value);
                        errors++;
                    end
                    if (o_out.lcm_value !== want.lcm_value) begin
                        $display("%0t: lcm_value mismatch, expected %h, got %h",
                                 $time, want.lcm_value, o_out.lcm_value);
                        errors++;
                    end
                    if (o_out.both_zero !== want.both_zero) begin
                        $display("%0t: both_zero mismatch, expected %b, got %b",
                                 $time, want.both_zero, o_out.both_zero);
                        errors++;
                    end
                end
                results_seen <= results_seen + 1;
                if ((results_seen + 1) % 40 == 0) begin
                    case ($urandom_range(2))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        default: stall_pct = 50;
                    endcase
                end
            end
            if (i_valid && !o_stall)
                expected_q.push_back(gcd_lcm_of(i_in));
            if (tail_phase) begin
                i_stall <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(7, 1) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] x, y, g;
        int unsigned wid;
        // zero cases, extremes, worst-case Euclid chain, common factors
        add_pair(32'd0, 32'd0, 1'b0);
        add_pair(32'd0, 32'd5, 1'b0);
        add_pair(32'd7, 32'd0, 1'b0);
        add_pair(32'd0, 32'hFFFF_FFFF, 1'b0);
        add_pair(32'hFFFF_FFFF, 32'd0, 1'b0);
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_pair(32'd1, 32'd1, 1'b0);
        add_pair(32'd1, 32'hFFFF_FFFF, 1'b0);
        add_pair(32'hFFFF_FFFF, 32'd1, 1'b0);
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        add_pair(32'd2971215073, 32'd1836311903, 1'b0);
        add_pair(32'd1836311903, 32'd2971215073, 1'b0);
        add_pair(32'd12, 32'd18, 1'b0);
        add_pair(32'd18, 32'd12, 1'b0);
        add_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
        add_pair(32'h8000_0000, 32'h4000_0000, 1'b0);
        add_pair(32'd4294967291, 32'd4294967279, 1'b0);
        add_pair(32'd6, 32'd35, 1'b0);
        add_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        add_pair(32'd65536, 32'd65537, 1'b0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    x = $urandom;
                    y = $urandom;
                end
                4, 5: begin
                    wid = $urandom_range(32, 1);
                    x = $urandom & (32'hFFFF_FFFF >> (32 - wid));
                    wid = $urandom_range(32, 1);
                    y = $urandom & (32'hFFFF_FFFF >> (32 - wid));
                end
                6: begin
                    g = $urandom_range(65535, 1);
                    x = g * $urandom_range(65535, 1);
                    y = g * $urandom_range(65535, 1);
                end
                7: begin
                    x = $urandom;
                    y = 32'd0;
                    if ($urandom_range(1))
                        {x, y} = {y, x};
                end
                8: begin
                    x = $urandom;
                    y = x;
                end
                default: begin
                    x = $urandom_range(15);
                    y = $urandom_range(15);
                end
            endcase
            add_pair(x, y, (n == 0 || n == RAND_ITEMS / 2));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || results_seen != items_sent)
            @(negedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d result transactions missing, expected %h, got none",
                     $time, expected_q.size(), expected_q[0]);
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
